>>> src/rbsi_pkg.sv
// Shared types, widths and constants of the ray/box slab intersection unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rbsi_pkg;

  localparam int unsigned EXT_W     = 31;  // half extent, unsigned Q15.16
  localparam int unsigned COORD_W   = 32;  // origin and direction, signed Q16.16
  localparam int unsigned MAG_W     = 32;  // magnitude of numerator and divisor
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned NUM_W     = MAG_W + FRAC_W;  // dividend width
  localparam int unsigned T_W       = NUM_W + 1;       // signed distance width
  localparam int unsigned NUM_AXES  = 3;
  localparam int unsigned NUM_FACES = 2 * NUM_AXES;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;

  localparam logic [EXT_W-1:0] EXT_RESET = EXT_W'(65536);
  localparam logic [EXT_W-1:0] DIST_MAX  = {EXT_W{1'b1}};

  typedef enum logic [1:0] {
    REG_HALF_X = 2'd0,
    REG_HALF_Y = 2'd1,
    REG_HALF_Z = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    FACE_NEG_X = 3'd0,
    FACE_POS_X = 3'd1,
    FACE_NEG_Y = 3'd2,
    FACE_POS_Y = 3'd3,
    FACE_NEG_Z = 3'd4,
    FACE_POS_Z = 3'd5
  } face_e;

  // Side information that travels alongside the dividers.
  typedef struct packed {
    logic [NUM_AXES-1:0]  dzero;  // direction component is zero
    logic [NUM_AXES-1:0]  dpos;   // direction component is positive
    logic [NUM_FACES-1:0] qneg;   // quotient of this face is negative
    logic                 zmiss;  // outside a slab with zero direction
  } meta_t;

  // Running entry and exit candidates.
  typedef struct packed {
    logic                  iok;
    logic                  ook;
    logic signed [T_W-1:0] tin;
    logic signed [T_W-1:0] tout;
    face_e                 fin;
    face_e                 fout;
  } span_t;

  function automatic face_e face_of(input logic [1:0] axis, input logic pos);
    face_e f;
    unique case (axis)
      2'd0:    f = pos ? FACE_POS_X : FACE_NEG_X;
      2'd1:    f = pos ? FACE_POS_Y : FACE_NEG_Y;
      2'd2:    f = pos ? FACE_POS_Z : FACE_NEG_Z;
      default: f = FACE_NEG_X;
    endcase
    return f;
  endfunction

  // Merge candidates of an earlier face group a with a later group b.
  // Ties keep the earlier face.
  function automatic span_t merge_span(input span_t a, input span_t b);
    span_t r;
    r = a;
    r.iok = a.iok | b.iok;
    r.ook = a.ook | b.ook;
    if (b.iok && (!a.iok || b.tin > a.tin)) begin
      r.tin = b.tin;
      r.fin = b.fin;
    end
    if (b.ook && (!a.ook || b.tout < a.tout)) begin
      r.tout = b.tout;
      r.fout = b.fout;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/rbsi_if.sv
// Handshake interfaces for the ray words in and the hit words out.
// Depends on rbsi_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rbsi_ray_if import rbsi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] origin_x;
  logic signed [COORD_W-1:0] origin_y;
  logic signed [COORD_W-1:0] origin_z;
  logic signed [COORD_W-1:0] dir_x;
  logic signed [COORD_W-1:0] dir_y;
  logic signed [COORD_W-1:0] dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface rbsi_hit_if import rbsi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [EXT_W-1:0] hit_distance;
  logic [2:0]       face_index;

  modport source (output valid, hit, hit_distance, face_index, input ready);
  modport sink   (input valid, hit, hit_distance, face_index, output ready);
endinterface

`default_nettype wire

>>> src/rbsi_div_pipe.sv
// Pipelined restoring divider, several lanes side by side, one quotient bit per stage.
// Depends on rbsi_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none

module rbsi_div_pipe import rbsi_pkg::*; #(
  parameter int unsigned NW    = NUM_W,
  parameter int unsigned DW    = MAG_W,
  parameter int unsigned LANES = NUM_FACES
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] dividend_i [LANES],
  input  logic [DW-1:0] divisor_i  [LANES],
  output logic [NW-1:0] quotient_o [LANES]
);

  // The dividend shifts out at the top of nq while quotient bits shift in below.
  logic [DW-1:0] rem_q [NW][LANES];
  logic [NW-1:0] nq_q  [NW][LANES];
  logic [DW-1:0] den_q [NW][LANES];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DW-1:0] rem_in;
      logic [DW-1:0] den_in;
      logic [NW-1:0] nq_in;
      logic [DW:0]   trial;
      logic          ge;

      if (s == 0) begin : g_first
        assign rem_in = '0;
        assign nq_in  = dividend_i[l];
        assign den_in = divisor_i[l];
      end else begin : g_next
        assign rem_in = rem_q[s-1][l];
        assign nq_in  = nq_q[s-1][l];
        assign den_in = den_q[s-1][l];
      end

      assign trial = {rem_in, nq_in[NW-1]};
      assign ge    = trial >= {1'b0, den_in};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s][l] <= ge ? DW'(trial - {1'b0, den_in}) : DW'(trial);
          nq_q[s][l]  <= {nq_in[NW-2:0], ge};
          den_q[s][l] <= den_in;
        end
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quotient_o[l] = nq_q[NW-1][l];
  end

endmodule

`default_nettype wire

>>> src/ray_box_slab_intersect_unit.sv
// Top level of the ray against box slab test: setup stage, dividers, face merge, output.
// Depends on rbsi_pkg, rbsi_if and rbsi_div_pipe.
//
//   port     | dir | kind        | carries
//   ---------+-----+-------------+------------------------------------------
//   ray_i    | in  | valid/ready | origin_x/y/z, dir_x/y/z (signed Q16.16)
//   hit_o    | out | valid/ready | hit, hit_distance, face_index
//   APB      | in  | psel/penable| half_extent_x/y/z at 0x0, 0x4, 0x8
//
// One ray word is taken every cycle while the output is not stalled; a result passes
// one setup stage, 48 divider stages (one quotient bit each), three merge stages
// and the output register. The 48-bit dividend sets the number of divider stages.
// Reset clears valid bits and loads the half extents with 1.0.
// When the output word is not taken the whole pipeline holds; ray_i.ready is
// low only then.
`timescale 1ns / 1ps
`default_nettype none

module ray_box_slab_intersect_unit import rbsi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  rbsi_ray_if.sink          ray_i,
  rbsi_hit_if.source        hit_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // Configuration registers.
  logic [EXT_W-1:0] ext_q [NUM_AXES];
  reg_idx_e         reg_idx;

  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) ext_q[a] <= EXT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_HALF_X: ext_q[0] <= pwdata[EXT_W-1:0];
        REG_HALF_Y: ext_q[1] <= pwdata[EXT_W-1:0];
        REG_HALF_Z: ext_q[2] <= pwdata[EXT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HALF_X: prdata = {1'b0, ext_q[0]};
      REG_HALF_Y: prdata = {1'b0, ext_q[1]};
      REG_HALF_Z: prdata = {1'b0, ext_q[2]};
      default:    prdata = '0;
    endcase
  end

  // Pipeline advance.
  logic out_vld_q;
  logic adv;

  assign adv         = !out_vld_q || hit_o.ready;
  assign ray_i.ready = adv;

  // Setup stage: numerator and divisor magnitudes with their signs.
  logic signed [COORD_W-1:0] org [NUM_AXES];
  logic signed [COORD_W-1:0] dir [NUM_AXES];
  logic [MAG_W+1:0]          np0 [NUM_AXES];  // -vn of the minus face
  logic [MAG_W+1:0]          np1 [NUM_AXES];  // -vn of the plus face
  logic [NUM_W-1:0]          num_d [NUM_FACES];
  logic [MAG_W-1:0]          den_d [NUM_FACES];
  meta_t                     meta_d;

  assign org[0] = ray_i.origin_x;
  assign org[1] = ray_i.origin_y;
  assign org[2] = ray_i.origin_z;
  assign dir[0] = ray_i.dir_x;
  assign dir[1] = ray_i.dir_y;
  assign dir[2] = ray_i.dir_z;

  always_comb begin
    logic [MAG_W-1:0] m0;
    logic [MAG_W-1:0] m1;
    logic [MAG_W-1:0] dm;
    meta_d = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      np0[a] = {{2{org[a][COORD_W-1]}}, org[a]} + {3'b000, ext_q[a]};
      np1[a] = {3'b000, ext_q[a]} - {{2{org[a][COORD_W-1]}}, org[a]};
      m0 = np0[a][MAG_W+1] ? MAG_W'((MAG_W+2)'(0) - np0[a]) : np0[a][MAG_W-1:0];
      m1 = np1[a][MAG_W+1] ? MAG_W'((MAG_W+2)'(0) - np1[a]) : np1[a][MAG_W-1:0];
      dm = dir[a][COORD_W-1] ? MAG_W'(MAG_W'(0) - MAG_W'(dir[a])) : MAG_W'(dir[a]);
      num_d[2*a]   = {m0, {FRAC_W{1'b0}}};
      num_d[2*a+1] = {m1, {FRAC_W{1'b0}}};
      den_d[2*a]   = dm;
      den_d[2*a+1] = dm;
      meta_d.dzero[a] = (dir[a] == '0);
      meta_d.dpos[a]  = !dir[a][COORD_W-1] && (dir[a] != '0);
      // The minus face divides by -d, the plus face by d.
      meta_d.qneg[2*a]   = np0[a][MAG_W+1] ^ meta_d.dpos[a];
      meta_d.qneg[2*a+1] = np1[a][MAG_W+1] ^ dir[a][COORD_W-1];
      if ((dir[a] == '0) && (np0[a][MAG_W+1] || np1[a][MAG_W+1])) begin
        meta_d.zmiss = 1'b1;
      end
    end
  end

  logic [NUM_W-1:0] num_q [NUM_FACES];
  logic [MAG_W-1:0] den_q [NUM_FACES];
  meta_t            meta_a_q;
  logic             vld_a_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q    <= num_d;
      den_q    <= den_d;
      meta_a_q <= meta_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else if (adv) begin
      vld_a_q <= ray_i.valid;
    end
  end

  // Dividers with side information shifted alongside.
  logic [NUM_W-1:0] quo [NUM_FACES];
  meta_t            meta_q [NUM_W];
  logic [NUM_W-1:0] vld_div_q;

  rbsi_div_pipe #(
    .NW    (NUM_W),
    .DW    (MAG_W),
    .LANES (NUM_FACES)
  ) u_div (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (num_q),
    .divisor_i  (den_q),
    .quotient_o (quo)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      meta_q[0] <= meta_a_q;
      for (int k = 1; k < NUM_W; k++) meta_q[k] <= meta_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_div_q <= '0;
    end else if (adv) begin
      vld_div_q <= {vld_div_q[NUM_W-2:0], vld_a_q};
    end
  end

  // Merge stage 1: signed distances, entry and exit face of each axis.
  meta_t mt;
  span_t span_d [NUM_AXES];

  assign mt = meta_q[NUM_W-1];

  always_comb begin
    logic signed [T_W-1:0] t0;
    logic signed [T_W-1:0] t1;
    for (int a = 0; a < NUM_AXES; a++) begin
      t0 = mt.qneg[2*a]   ? T_W'(0) - {1'b0, quo[2*a]}   : {1'b0, quo[2*a]};
      t1 = mt.qneg[2*a+1] ? T_W'(0) - {1'b0, quo[2*a+1]} : {1'b0, quo[2*a+1]};
      span_d[a].iok = !mt.dzero[a];
      span_d[a].ook = !mt.dzero[a];
      if (mt.dpos[a]) begin
        span_d[a].tin  = t0;
        span_d[a].fin  = face_of(2'(a), 1'b0);
        span_d[a].tout = t1;
        span_d[a].fout = face_of(2'(a), 1'b1);
      end else begin
        span_d[a].tin  = t1;
        span_d[a].fin  = face_of(2'(a), 1'b1);
        span_d[a].tout = t0;
        span_d[a].fout = face_of(2'(a), 1'b0);
      end
    end
  end

  span_t span1_q [NUM_AXES];
  logic  zmiss1_q;
  span_t span_xy_q;
  span_t span_z2_q;
  logic  zmiss2_q;
  span_t span3_q;
  logic  zmiss3_q;
  logic  vld1_q;
  logic  vld2_q;
  logic  vld3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      span1_q   <= span_d;
      zmiss1_q  <= mt.zmiss;
      span_xy_q <= merge_span(span1_q[0], span1_q[1]);
      span_z2_q <= span1_q[2];
      zmiss2_q  <= zmiss1_q;
      span3_q   <= merge_span(span_xy_q, span_z2_q);
      zmiss3_q  <= zmiss2_q;
    end
  end

  // Final decision and saturation.
  localparam logic signed [T_W-1:0] TMAX = {{(T_W-EXT_W){1'b0}}, DIST_MAX};

  logic             miss;
  logic [EXT_W-1:0] dist_d;
  face_e            face_d;

  always_comb begin
    logic signed [T_W-1:0] t;
    miss = zmiss3_q ||
           (span3_q.ook && (span3_q.tout < 0 ||
                            (span3_q.iok && span3_q.tout < span3_q.tin)));
    // Starting inside, or no entry face at all, reports the exit.
    if (!span3_q.iok || span3_q.tin < 0) begin
      t      = span3_q.ook ? span3_q.tout : TMAX;
      face_d = span3_q.ook ? span3_q.fout : FACE_NEG_X;
    end else begin
      t      = span3_q.tin;
      face_d = span3_q.fin;
    end
    if (t > TMAX) begin
      dist_d = DIST_MAX;
    end else if (t < 0) begin
      dist_d = '0;
    end else begin
      dist_d = t[EXT_W-1:0];
    end
    if (miss) begin
      dist_d = '0;
      face_d = FACE_NEG_X;
    end
  end

  logic             hit_q;
  logic [EXT_W-1:0] dist_q;
  face_e            face_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q  <= !miss;
      dist_q <= dist_d;
      face_q <= face_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      vld3_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld1_q    <= vld_div_q[NUM_W-1];
      vld2_q    <= vld1_q;
      vld3_q    <= vld2_q;
      out_vld_q <= vld3_q;
    end
  end

  assign hit_o.valid        = out_vld_q;
  assign hit_o.hit          = hit_q;
  assign hit_o.hit_distance = dist_q;
  assign hit_o.face_index   = face_q;

endmodule

`default_nettype wire

>>> src/rbsi_checker.sv
// Port-level checks of the slab intersection unit, bound to its top level.
// Depends on rbsi_pkg and ray_box_slab_intersect_unit.
`timescale 1ns / 1ps
`default_nettype none

module rbsi_checker import rbsi_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             hit_i,
  input logic [EXT_W-1:0] dist_i,
  input logic [2:0]       face_i
);

  // A result word stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // A miss reports zero distance and the first face.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !hit_i |-> dist_i == '0 && face_i == FACE_NEG_X)
    else $error("miss with nonzero distance or face");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> face_i <= FACE_POS_Z)
    else $error("face index out of range");

  // With no result waiting the pipeline always takes a new word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

endmodule

bind ray_box_slab_intersect_unit rbsi_checker u_rbsi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (ray_i.ready),
  .out_valid_i (hit_o.valid),
  .out_ready_i (hit_o.ready),
  .hit_i       (hit_o.hit),
  .dist_i      (hit_o.hit_distance),
  .face_i      (hit_o.face_index)
);

`default_nettype wire

>>> verif/ray_box_slab_intersect_unit_tb.sv
// Self-checking testbench for the ray/box slab intersection unit.
// Drives ray words and APB register writes, predicts each hit word and compares in order.
// Depends on rbsi_pkg, rbsi_if and the unit itself.
`timescale 1ns / 1ps

module ray_box_slab_intersect_unit_tb import rbsi_pkg::*; ();

  typedef struct packed {
    logic signed [COORD_W-1:0] ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct packed {
    logic             hit;
    logic [EXT_W-1:0] dist_val;
    logic [2:0]       face;
  } hit_t;

  localparam int LATENCY = 53;
  localparam int LIMIT   = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  rbsi_ray_if ray_bus ();
  rbsi_hit_if hit_bus ();

  ray_box_slab_intersect_unit uut (
    .clk_i(clk), .rst_ni(rst_n), .ray_i(ray_bus.sink), .hit_o(hit_bus.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [EXT_W-1:0] box_half [NUM_AXES];
  ray_t pending_rays[$];
  hit_t expected_hits[$];
  int   mismatches = 0;
  int   cycles = 0;
  bit   calm_in = 1'b0, calm_out = 1'b0;
  bit   send_hold = 1'b0;

  function automatic void queue_ray(input ray_t r);
    pending_rays.insert(pending_rays.size(), r);
  endfunction

  function automatic hit_t slab_hit(input ray_t r);
    logic signed [63:0] org [3], dir [3];
    logic signed [63:0] vn, vd, t, t_in, t_out, t_hit;
    bit in_ok, out_ok, miss;
    logic [2:0] f_in, f_out, face;
    hit_t h;
    org[0] = r.ox; org[1] = r.oy; org[2] = r.oz;
    dir[0] = r.dx; dir[1] = r.dy; dir[2] = r.dz;
    in_ok = 0; out_ok = 0; miss = 0; t_in = 0; t_out = 0; f_in = 0; f_out = 0;
    for (int a = 0; a < 3; a++) begin
      for (int s = 0; s < 2; s++) begin
        vn = (s ? org[a] : -org[a]) - $signed({33'd0, box_half[a]});
        vd = s ? dir[a] : -dir[a];
        if (vd == 0) begin
          if (vn > 0) miss = 1;
        end else begin
          t = (-vn * 64'sd65536) / vd;
          if (vd > 0) begin
            if (!out_ok || t < t_out) begin
              t_out = t; f_out = 3'(2 * a + s); out_ok = 1;
            end
          end else if (!in_ok || t > t_in) begin
            t_in = t; f_in = 3'(2 * a + s); in_ok = 1;
          end
        end
      end
    end
    if (!miss && out_ok && (t_out < 0 || (in_ok && t_out < t_in))) miss = 1;
    h = '0;
    if (!miss) begin
      if (!in_ok || t_in < 0) begin
        t_hit = out_ok ? t_out : 64'sh7FFFFFFF;
        face = out_ok ? f_out : FACE_NEG_X;
      end else begin
        t_hit = t_in;
        face = f_in;
      end
      if (t_hit > 64'sh7FFFFFFF) t_hit = 64'sh7FFFFFFF;
      if (t_hit < 0) t_hit = 0;
      h.hit = 1'b1;
      h.dist_val = t_hit[EXT_W-1:0];
      h.face = face;
    end
    return h;
  endfunction

  // Driver: presents the oldest pending ray, idles at random.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (ray_bus.valid && ray_bus.ready) begin
        expected_hits.insert(expected_hits.size(), slab_hit(pending_rays.pop_front()));
      end
      if ((!ray_bus.valid || ray_bus.ready) || !rst_n) begin
        if (pending_rays.size() != 0 && !send_hold &&
            (calm_in || $urandom_range(99) >= 16)) begin
          ray_bus.valid <= 1'b1;
          {ray_bus.origin_x, ray_bus.origin_y, ray_bus.origin_z,
           ray_bus.dir_x, ray_bus.dir_y, ray_bus.dir_z} <= pending_rays[0];
        end else begin
          ray_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: backpressure and in-order comparison.
  always @(posedge clk) begin
    hit_t got, want;
    if (rst_n) begin
      hit_bus.ready <= calm_out || ($urandom_range(99) >= 16);
      if (hit_bus.valid && hit_bus.ready) begin
        got = {hit_bus.hit, hit_bus.hit_distance, hit_bus.face_index};
        if (expected_hits.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected hit word %h", got);
        end else begin
          want = expected_hits.pop_front();
          if (got !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("hit mismatch: exp hit=%0d dist=%h face=%0d, got hit=%0d dist=%h face=%0d",
                       want.hit, want.dist_val, want.face, got.hit, got.dist_val, got.face);
          end
        end
      end
    end
  end

  initial begin
    ray_bus.valid = 1'b0;
    {ray_bus.origin_x, ray_bus.origin_y, ray_bus.origin_z} = '0;
    {ray_bus.dir_x, ray_bus.dir_y, ray_bus.dir_z} = '0;
    hit_bus.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (cycles >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [EXT_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_W'(4 * idx); pwdata <= {1'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    box_half[idx] = value;
  endtask

  task automatic drain();
    while (pending_rays.size() != 0 || expected_hits.size() != 0 || ray_bus.valid)
      @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(input int scale);
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2 * scale)) - scale);
      2: return 32'h0;
      3: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(8 * scale)) - 4 * scale);
    endcase
  endfunction

  function automatic ray_t rand_ray(input int scale);
    ray_t r;
    r.ox = rand_coord(scale); r.oy = rand_coord(scale); r.oz = rand_coord(scale);
    r.dx = rand_coord(scale); r.dy = rand_coord(scale); r.dz = rand_coord(scale);
    return r;
  endfunction

  function automatic logic [EXT_W-1:0] rand_half();
    case ($urandom_range(3))
      0: return '0;
      1: return DIST_MAX;
      default: return EXT_W'($urandom_range(1 << 20));
    endcase
  endfunction

  localparam logic signed [31:0] ONE = 32'sh10000;

  initial begin
    box_half[0] = EXT_RESET; box_half[1] = EXT_RESET; box_half[2] = EXT_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    write_reg(REG_HALF_X, EXT_RESET);
    write_reg(REG_HALF_Y, 31'h20000);
    write_reg(REG_HALF_Z, 31'h8000);
    // Directed: axis hits on every face, start inside, zero directions, extremes.
    queue_ray('{-3*ONE, 0, 0, ONE, 0, 0});
    queue_ray('{3*ONE, 0, 0, -ONE, 0, 0});
    queue_ray('{0, -5*ONE, 0, 0, ONE, 0});
    queue_ray('{0, 5*ONE, 0, 0, -ONE, 0});
    queue_ray('{0, 0, -2*ONE, 0, 0, ONE});
    queue_ray('{0, 0, 2*ONE, 0, 0, -ONE});
    queue_ray('{0, 0, 0, ONE, ONE, ONE});
    queue_ray('{0, 0, 0, 0, 0, 0});
    queue_ray('{3*ONE, 0, 0, 0, 0, 0});
    queue_ray('{3*ONE, 0, 0, ONE, 0, 0});
    queue_ray('{-3*ONE, 3*ONE, 0, ONE, 0, 0});
    queue_ray('{-3*ONE, -3*ONE, 0, ONE, ONE, 0});
    queue_ray('{32'sh80000000, 0, 0, 1, 0, 0});
    queue_ray('{32'sh80000000, 32'sh80000000, 32'sh80000000,
                32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF});
    queue_ray('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                32'sh80000000, 32'sh80000000, 32'sh80000000});
    queue_ray('{-1, -1, -1, -1, -1, -1});
    queue_ray('{ONE, 0, 0, ONE, 0, 0});
    drain();
    write_reg(REG_HALF_X, '0);
    write_reg(REG_HALF_Y, DIST_MAX);
    write_reg(REG_HALF_Z, '0);
    queue_ray('{0, 0, 0, 0, 0, 0});
    queue_ray('{-ONE, 0, 0, ONE, 0, 0});
    queue_ray('{0, 32'sh7FFFFFFF, 0, 0, 1, 0});
    drain();
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_HALF_X, rand_half());
      write_reg(REG_HALF_Y, rand_half());
      write_reg(REG_HALF_Z, rand_half());
      calm_in = (phase == 2);
      calm_out = (phase == 2);
      for (int i = 0; i < 300; i++) begin
        queue_ray(rand_ray(phase < 3 ? 4 << 16 : 1 << 12));
        if (i == 150 && phase == 4) begin
          // Hold the sender until the pipeline has emptied.
          while (pending_rays.size() != 0) @(posedge clk);
          send_hold = 1'b1;
          while (expected_hits.size() != 0 || ray_bus.valid) @(posedge clk);
          send_hold = 1'b0;
        end
      end
      drain();
    end
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
